// ----- design/snnu_pkg.sv -----
// ----------------------------------------------------------------------------
// snnu_pkg
// Shared types, codes and the assessment norm for the signed network norm
// update block.
// ----------------------------------------------------------------------------
package snnu_pkg;

    // Default matrix size
    localparam int AGENTS_DEF = 32;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 5;
    localparam int ROW_W      = 32;
    localparam int IN_DATA_W  = 48;   // 5 + 32 + 5 + 5 = 47, padded to bytes
    localparam int OUT_DATA_W = 40;   // 32 + 1 = 33, padded to bytes

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_RULE_MODE = 1'b0;   // register index, paddr[2]

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Assessment norms
    typedef enum logic [1:0] {
        RULE_L4 = 2'd0,
        RULE_L6 = 2'd1,
        RULE_L7 = 2'd2,
        RULE_L8 = 2'd3
    } rule_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;        // capture the input beat
        logic exec;         // write row or update column
        logic sweep_step;   // check one donor/recipient pair
        logic load_out;     // load the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_step;
        logic sweep_end;
    } dp_status_t;

    // a = M[o][d], b = M[d][r], c = M[o][r]; 1 means +1
    function automatic logic norm(rule_t mode, logic a, logic b, logic c);
        logic res;
        case (mode)
            RULE_L4: res = b ? (a | c) : ~c;
            RULE_L6: res = ~(b ^ c);
            RULE_L7: res = b ? (a | c) : (a & ~c);
            RULE_L8: res = b ? c : (a & ~c);
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ----- design/snnu_ctrl.sv -----
// ----------------------------------------------------------------------------
// snnu_ctrl
// Sequencer: accepts one beat, runs the row access or the column update and
// absorption sweep, then hands the result to the output register.
// ----------------------------------------------------------------------------
module snnu_ctrl
    import snnu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        cmd.latch      = s_tvalid && (state_reg == ST_IDLE);
        cmd.exec       = (state_reg == ST_EXEC);
        cmd.sweep_step = (state_reg == ST_SWEEP);
        cmd.load_out   = (state_reg == ST_RESULT) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = status.is_step ? ST_SWEEP : ST_RESULT;
            end
            ST_SWEEP:
            begin
                if (status.sweep_end)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // a new result wins over the beat leaving this cycle
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten while held");

    a_sweep_only_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_step |-> status.is_step)
        else $error("sweep running for a non-step command");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> cmd.exec)
        else $error("accepted beat not executed next cycle");

endmodule

// ----- design/snnu_datapath.sv -----
// ----------------------------------------------------------------------------
// snnu_datapath
// Opinion matrix with one lane per observer row, pair counters for the
// absorption sweep, item capture and output register.
// ----------------------------------------------------------------------------
module snnu_datapath
    import snnu_pkg::*;
#(
    parameter int AGENTS = AGENTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  rule_t                 rule_mode,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic [ROW_W-1:0]      row_data,
    output logic                  absorbing
);

    localparam int AW = $clog2(AGENTS);

    // captured item
    logic [CMD_W-1:0] cmd_reg;
    logic [IDX_W-1:0] row_index_reg;
    logic [ROW_W-1:0] row_bits_reg;
    logic [IDX_W-1:0] donor_reg;
    logic [IDX_W-1:0] recipient_reg;

    logic [AGENTS-1:0] mat_reg  [AGENTS];
    logic [AGENTS-1:0] mat_next [AGENTS];

    logic [AW-1:0] d_cnt_reg;
    logic [AW-1:0] d_cnt_next;
    logic [AW-1:0] r_cnt_reg;
    logic [AW-1:0] r_cnt_next;
    logic          abs_reg;
    logic          abs_next;
    logic [ROW_W-1:0] out_row_reg;
    logic [ROW_W-1:0] out_row_next;
    logic             out_abs_reg;
    logic             out_abs_next;

    logic              row_ok;
    logic              pair_ok;
    logic [AW-1:0]     row_ix;
    logic [AW-1:0]     sel_d;
    logic [AW-1:0]     sel_r;
    logic [AGENTS-1:0] col_d;
    logic [AGENTS-1:0] col_r;
    logic [AGENTS-1:0] fresh;
    logic              b_bit;
    logic              mismatch;
    logic              pair_last;
    logic [AGENTS+ROW_W-1:0] wr_ext;
    logic [AGENTS-1:0]       wr_row;
    logic [AGENTS+ROW_W-1:0] rd_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg       <= s_tuser;
            row_index_reg <= s_tdata[4:0];
            row_bits_reg  <= s_tdata[36:5];
            donor_reg     <= s_tdata[41:37];
            recipient_reg <= s_tdata[46:42];
        end
    end

    assign row_ok  = 32'(row_index_reg) < 32'(AGENTS);
    assign pair_ok = (32'(donor_reg) < 32'(AGENTS)) && (32'(recipient_reg) < 32'(AGENTS));
    assign row_ix  = AW'(row_index_reg);

    // column selects: the item's pair during update, the counters during sweep
    assign sel_d = cmd.sweep_step ? d_cnt_reg : AW'(donor_reg);
    assign sel_r = cmd.sweep_step ? r_cnt_reg : AW'(recipient_reg);

    // observer lanes
    always_comb
    begin
        for (int o = 0; o < AGENTS; o++)
        begin
            col_d[o] = mat_reg[o][sel_d];
            col_r[o] = mat_reg[o][sel_r];
        end
        b_bit = col_r[sel_d];
        for (int o = 0; o < AGENTS; o++)
            fresh[o] = norm(rule_mode, col_d[o], b_bit, col_r[o]);
    end

    assign mismatch  = |(fresh ^ col_d);
    assign pair_last = (d_cnt_reg == AW'(AGENTS - 1)) && (r_cnt_reg == AW'(AGENTS - 1));

    assign status.is_step   = (cmd_reg == CMD_STEP);
    assign status.sweep_end = mismatch || pair_last;

    // drop row bits above the matrix width, zero-fill below it
    assign wr_ext = {AGENTS'(0), row_bits_reg};
    assign wr_row = wr_ext[AGENTS-1:0];
    assign rd_ext = {ROW_W'(0), mat_reg[row_ix]};

    always_comb
    begin
        for (int o = 0; o < AGENTS; o++)
            mat_next[o] = mat_reg[o];
        if (cmd.exec)
        begin
            if (cmd_reg == CMD_WRITE && row_ok)
                mat_next[row_ix] = wr_row;
            else if (cmd_reg == CMD_STEP && pair_ok)
            begin
                for (int o = 0; o < AGENTS; o++)
                    mat_next[o][sel_d] = fresh[o];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int o = 0; o < AGENTS; o++)
                mat_reg[o] <= '0;
        end
        else
        begin
            for (int o = 0; o < AGENTS; o++)
                mat_reg[o] <= mat_next[o];
        end
    end

    always_comb
    begin
        d_cnt_next = d_cnt_reg;
        r_cnt_next = r_cnt_reg;
        abs_next   = abs_reg;
        if (cmd.exec)
        begin
            d_cnt_next = '0;
            r_cnt_next = '0;
        end
        else if (cmd.sweep_step)
        begin
            abs_next = !mismatch;
            if (r_cnt_reg == AW'(AGENTS - 1))
            begin
                r_cnt_next = '0;
                d_cnt_next = d_cnt_reg + AW'(1);
            end
            else
                r_cnt_next = r_cnt_reg + AW'(1);
        end
    end

    always_comb
    begin
        out_row_next = out_row_reg;
        out_abs_next = out_abs_reg;
        if (cmd.load_out)
        begin
            out_row_next = (cmd_reg == CMD_READ && row_ok) ? rd_ext[ROW_W-1:0] : '0;
            out_abs_next = (cmd_reg == CMD_STEP) && abs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_cnt_reg   <= '0;
            r_cnt_reg   <= '0;
            abs_reg     <= 1'b0;
            out_row_reg <= '0;
            out_abs_reg <= 1'b0;
        end
        else
        begin
            d_cnt_reg   <= d_cnt_next;
            r_cnt_reg   <= r_cnt_next;
            abs_reg     <= abs_next;
            out_row_reg <= out_row_next;
            out_abs_reg <= out_abs_next;
        end
    end

    assign row_data  = out_row_reg;
    assign absorbing = out_abs_reg;

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_abs_reg |-> (out_row_reg == '0))
        else $error("absorbing flag set alongside row data");

    a_sweep_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (d_cnt_reg == '0 && r_cnt_reg == '0))
        else $error("pair counters not cleared before sweep");

endmodule

// ----- design/signed_network_norm_update.sv -----
// ----------------------------------------------------------------------------
// signed_network_norm_update
// Signed opinion matrix with norm-driven column update and absorption check.
// ----------------------------------------------------------------------------
// Input stream (s_*): one beat per command. s_tuser carries the command
// (write row, step, read row); s_tdata carries row index, row bits, donor
// and recipient. Output stream (m_*): one beat per input beat, carrying the
// row for a read and the absorbing flag after a step.
// rule_mode is written over the APB port at address 0; the user must see that
// it is written only while the block is idle, as the block itself does not
// enforce this. pready is always high. Write, read and unused commands pass
// through the execute and result states. A step first rewrites column d
// across all observer lanes, then sweeps donor/recipient pairs one per cycle,
// stopping at the first pair that would change an opinion or after all
// AGENTS^2 pairs.
// One command is in flight at a time; s_tready is high only when idle.
// Reset clears the whole matrix (all opinions -1) and selects norm L4.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and finishes up to its result, then waits.
// ----------------------------------------------------------------------------
module signed_network_norm_update
    import snnu_pkg::*;
#(
    parameter int AGENTS = AGENTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // row_index, row_bits, donor, recipient, pad
    input  logic [CMD_W-1:0]       s_tuser,   // command
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // row_data, absorbing, pad
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    rule_t      rule_mode_reg;
    rule_t      rule_mode_next;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic [ROW_W-1:0] row_data;
    logic             absorbing;
    logic             reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_RULE_MODE);

    always_comb
    begin
        rule_mode_next = rule_mode_reg;
        if (psel && penable && pwrite && reg_hit)
            rule_mode_next = rule_t'(pwdata[1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rule_mode_reg <= RULE_L4;
        else
            rule_mode_reg <= rule_mode_next;
    end

    assign prdata = reg_hit ? APB_DATA_W'(rule_mode_reg) : '0;

    snnu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    snnu_datapath #(
        .AGENTS (AGENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .rule_mode (rule_mode_reg),
        .cmd       (cmd),
        .status    (status),
        .row_data  (row_data),
        .absorbing (absorbing)
    );

    assign m_tdata = {7'd0, absorbing, row_data};

endmodule

// ----- tb/sv/snnu_checker.sv -----
// ----------------------------------------------------------------------------
// snnu_checker
// Watches the command, result and APB channels of the signed network norm
// update block. Keeps its own copy of the opinion matrix and the selected
// norm, predicts one result per accepted command and compares each result
// beat with the oldest prediction.
// ----------------------------------------------------------------------------
module snnu_checker
    import snnu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,    // row_index, row_bits, donor, recipient, pad
    input  logic [CMD_W-1:0]      s_tuser,    // command
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,    // row_data, absorbing, pad
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = AGENTS_DEF;

    typedef struct packed {
        logic [ROW_W-1:0] row_data;
        logic             absorbing;
    } opinion_result_t;

    logic [N-1:0]    opinions [N];
    rule_t           norm_sel;
    opinion_result_t outcome_q [$];
    opinion_result_t oldest;
    int              fail_cnt = 0;

    // Lane-wise norm: a = M[o][d], b = M[d][r], c = M[o][r], 1 means +1
    function automatic logic [N-1:0] assess(rule_t sel, logic [N-1:0] a,
                                            logic [N-1:0] b, logic [N-1:0] c);
        logic [N-1:0] res;
        case (sel)
            RULE_L4: res = (b & (a | c)) | (~b & ~c);
            RULE_L6: res = ~(b ^ c);
            RULE_L7: res = (b & (a | c)) | (~b & a & ~c);
            default: res = (b & c) | (~b & a & ~c);
        endcase
        return res;
    endfunction

    function automatic opinion_result_t predict_outcome(logic [CMD_W-1:0] cmd,
                                                        logic [IDX_W-1:0] idx,
                                                        logic [ROW_W-1:0] bits,
                                                        logic [IDX_W-1:0] d,
                                                        logic [IDX_W-1:0] r);
        opinion_result_t res;
        logic [N-1:0]    a_col;
        logic [N-1:0]    c_col;
        logic [N-1:0]    fresh;
        logic            b;
        logic            a;
        res = '0;
        case (cmd)
            CMD_WRITE: opinions[idx] = bits[N-1:0];
            CMD_READ:  res.row_data = ROW_W'(opinions[idx]);
            CMD_STEP:
            begin
                // all new opinions come from the old matrix
                b = opinions[d][r];
                for (int o = 0; o < N; o++)
                begin
                    a_col[o] = opinions[o][d];
                    c_col[o] = opinions[o][r];
                end
                fresh = assess(norm_sel, a_col, {N{b}}, c_col);
                for (int o = 0; o < N; o++)
                    opinions[o][d] = fresh[o];
                res.absorbing = 1'b1;
                for (int o = 0; o < N; o++)
                    for (int dd = 0; dd < N; dd++)
                    begin
                        a = opinions[o][dd];
                        if (assess(norm_sel, {N{a}}, opinions[dd], opinions[o]) != {N{a}})
                            res.absorbing = 1'b0;
                    end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic note_failure(string msg);
        if (fail_cnt < 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int o = 0; o < N; o++)
                opinions[o] = '0;
            norm_sel = RULE_L4;
            outcome_q.delete();
        end
        else
        begin
            if (psel && penable && pready && paddr[2] == REG_RULE_MODE)
            begin
                if (pwrite)
                    norm_sel = rule_t'(pwdata[1:0]);
                else if (prdata !== APB_DATA_W'(norm_sel))
                    note_failure($sformatf("rule_mode read expected %0d, got %h",
                                           norm_sel, prdata));
            end
            if (s_tvalid && s_tready)
                outcome_q.insert(outcome_q.size(),
                    predict_outcome(s_tuser, s_tdata[IDX_W-1:0],
                    s_tdata[IDX_W +: ROW_W], s_tdata[IDX_W+ROW_W +: IDX_W],
                    s_tdata[2*IDX_W+ROW_W +: IDX_W]));
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                    note_failure($sformatf("result beat with nothing pending: %h", m_tdata));
                else
                begin
                    oldest = outcome_q.pop_front();
                    if (m_tdata[ROW_W-1:0] !== oldest.row_data)
                        note_failure($sformatf("row_data expected %h, got %h",
                                               oldest.row_data, m_tdata[ROW_W-1:0]));
                    if (m_tdata[ROW_W] !== oldest.absorbing)
                        note_failure($sformatf("absorbing expected %b, got %b",
                                               oldest.absorbing, m_tdata[ROW_W]));
                end
            end
        end
        mismatches <= fail_cnt;
        pending    <= outcome_q.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the signed network norm update block with directed commands and
// then with phases of structured opinion matrices (group partitions, their
// complements, blank and random rows, some perturbed or partly loaded)
// followed by mixed steps, reads, writes and spare commands under each norm. Both stream
// sides idle at random; one phase runs without idling and one holds the
// result side off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import snnu_pkg::*;

    localparam int ITEMS        = 580;
    localparam int LIMIT        = 3_000_000;
    localparam int DRAIN_CYCLES = AGENTS_DEF * AGENTS_DEF + 8;
    localparam int HOLD_CYCLES  = 2500;
    localparam int IDLE_PCT     = 22;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // row_index, row_bits, donor, recipient, pad
    logic [CMD_W-1:0]      s_tuser  = '0;   // command
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // row_data, absorbing, pad
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int cycle_cnt = 0;
    int sent      = 0;
    bit idle_en   = 1'b1;
    bit hold_req  = 1'b0;

    rule_t rule_order [4] = '{RULE_L8, RULE_L4, RULE_L6, RULE_L7};

    always #2 clk = ~clk;

    signed_network_norm_update #(
        .AGENTS(AGENTS_DEF)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    snnu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Called and returns at a falling edge; valid stays up between beats unless an idle gap is drawn
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic [ROW_W-1:0] bits, input logic [IDX_W-1:0] d,
                            input logic [IDX_W-1:0] r);
        while (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, r, d, bits, idx};
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
        @(negedge clk);
    endtask

    // Optional write of rule_mode, then a read back
    task automatic rule_access(input bit wr, input rule_t sel);
        logic [APB_DATA_W-1:0] word;
        word      = $urandom;
        word[1:0] = sel;
        psel    <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_RULE_MODE, 2'b00};
        if (wr)
        begin
            pwrite <= 1'b1;
            pwdata <= word;
            @(negedge clk);
            penable <= 1'b1;
            @(negedge clk);
            penable <= 1'b0;
        end
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [ROW_W-1:0] rows [AGENTS_DEF];
        int               grp [AGENTS_DEF];
        int               phase;
        int               kind;
        int               groups;
        int               fill;
        int               pick;
        int               col;
        rule_t            sel;
        logic [IDX_W-1:0] dd;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        rule_access(1'b0, RULE_L4);

        // Directed: extremes, every command, donor as observer and recipient
        send_cmd(CMD_WRITE, 5'd0,  32'hFFFF_FFFF, 5'd0, 5'd0);
        send_cmd(CMD_WRITE, 5'd31, 32'h0000_0000, 5'd31, 5'd31);
        send_cmd(CMD_WRITE, 5'd5,  32'hA5A5_A5A5, 5'd0, 5'd31);
        send_cmd(CMD_WRITE, 5'd30, 32'h5A5A_5A5A, 5'd31, 5'd0);
        send_cmd(CMD_READ,  5'd0,  32'h0000_0000, 5'd0, 5'd0);
        send_cmd(CMD_READ,  5'd31, 32'hFFFF_FFFF, 5'd31, 5'd31);
        send_cmd(CMD_READ,  5'd5,  32'h0000_0000, 5'd0, 5'd0);
        send_cmd(CMD_READ,  5'd12, 32'h0000_0000, 5'd0, 5'd0);
        send_cmd(CMD_STEP,  5'd0,  32'h0000_0000, 5'd0, 5'd0);
        send_cmd(CMD_STEP,  5'd31, 32'hFFFF_FFFF, 5'd31, 5'd31);
        send_cmd(CMD_STEP,  5'd0,  32'h0000_0000, 5'd5, 5'd30);
        send_cmd(CMD_STEP,  5'd0,  32'h0000_0000, 5'd0, 5'd31);
        send_cmd(CMD_STEP,  5'd0,  32'h0000_0000, 5'd30, 5'd5);
        send_cmd(CMD_SPARE, 5'd31, 32'hFFFF_FFFF, 5'd31, 5'd31);
        send_cmd(CMD_SPARE, 5'd0,  32'h0000_0000, 5'd0, 5'd0);
        send_cmd(CMD_READ,  5'd5,  32'h0000_0000, 5'd0, 5'd0);
        send_cmd(CMD_READ,  5'd30, 32'h0000_0000, 5'd0, 5'd0);

        phase = 0;
        while (sent < ITEMS)
        begin
            s_tvalid <= 1'b0;
            while (pending != 0)
                @(negedge clk);
            sel = (phase < 4) ? rule_order[phase] : rule_t'($urandom_range(3));
            rule_access(1'b1, sel);
            idle_en = (phase != 2);
            if (phase == 4)
                hold_req = 1'b1;

            // Build a matrix: mostly group partitions, some noise
            kind   = $urandom_range(9);
            groups = $urandom_range(1, 4);
            foreach (grp[j])
                grp[j] = $urandom_range(groups - 1);
            for (int o = 0; o < AGENTS_DEF; o++)
            begin
                for (int j = 0; j < AGENTS_DEF; j++)
                    rows[o][j] = (grp[o] == grp[j]);
                if (kind == 7)
                    rows[o] = ~rows[o];
                else if (kind == 8)
                    rows[o] = '0;
                else if (kind == 9)
                    rows[o] = $urandom;
            end
            if ($urandom_range(1) == 1)
                repeat ($urandom_range(1, 3))
                begin
                    pick = $urandom_range(AGENTS_DEF - 1);
                    col  = $urandom_range(AGENTS_DEF - 1);
                    rows[pick][col] = ~rows[pick][col];
                end
            fill = ($urandom_range(4) == 0) ? $urandom_range(1, AGENTS_DEF - 1) : AGENTS_DEF;
            for (int o = 0; o < fill; o++)
                send_cmd(CMD_WRITE, IDX_W'(o), rows[o], IDX_W'($urandom), IDX_W'($urandom));

            repeat ($urandom_range(10, 25))
            begin
                pick = $urandom_range(99);
                dd   = IDX_W'($urandom);
                if (pick < 60)
                    send_cmd(CMD_STEP, IDX_W'($urandom), $urandom, dd,
                             ($urandom_range(9) == 0) ? dd : IDX_W'($urandom));
                else if (pick < 80)
                    send_cmd(CMD_READ, dd, $urandom, IDX_W'($urandom), IDX_W'($urandom));
                else if (pick < 92)
                    send_cmd(CMD_WRITE, dd, $urandom, IDX_W'($urandom), IDX_W'($urandom));
                else
                    send_cmd(CMD_SPARE, dd, $urandom, IDX_W'($urandom), IDX_W'($urandom));
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/snnu_pkg.sv
design/snnu_ctrl.sv
design/snnu_datapath.sv
design/signed_network_norm_update.sv
tb/sv/snnu_checker.sv
tb/sv/testbench.sv
